// ----- sv/wwm_pkg.sv -----
// Shared constants and types for the whole-word match counter.
`timescale 1ns / 1ps

package wwm_pkg;

  localparam int MAX_WORD   = 16;
  localparam int WIN_DEPTH  = MAX_WORD + 1;
  localparam int LEN_BITS   = $clog2(WIN_DEPTH);
  localparam int POS_BITS   = 20;
  localparam int COUNT_BITS = 20;
  localparam int CFG_BITS   = 64;
  localparam int IDX_BITS   = 2;

  localparam logic [7:0]            SPACE_BYTE = 8'h20;
  localparam logic [POS_BITS-1:0]   POS_MAX    = {POS_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};

  typedef logic [7:0] byte_t;

  typedef enum logic [IDX_BITS-1:0] {
    CFG_WORD_LENGTH = 2'd0,
    CFG_BYTES_LOW   = 2'd1,
    CFG_BYTES_HIGH  = 2'd2
  } cfg_idx_t;

  // compare results of one window cell, for the held byte and the incoming one
  typedef struct packed {
    logic eq_now;
    logic eq_next;
    logic sp_now;
    logic sp_next;
  } cell_flags_t;

endpackage

// ----- sv/wwm_cell.sv -----
// One byte cell of the shifting text window with its compare logic.
`timescale 1ns / 1ps

module wwm_cell import wwm_pkg::*; (
  input  logic        clk,
  input  logic        shift_en,
  input  byte_t       din,
  input  byte_t       exp_byte,
  output byte_t       dout,
  output cell_flags_t flags
);

  byte_t byte_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= din;
    end
  end

  assign dout          = byte_r;
  assign flags.eq_now  = (byte_r == exp_byte);
  assign flags.eq_next = (din == exp_byte);
  assign flags.sp_now  = (byte_r == SPACE_BYTE);
  assign flags.sp_next = (din == SPACE_BYTE);

endmodule

// ----- sv/wwm_cfg.sv -----
// Configuration registers and per-cell expected bytes aligned to the word length.
`timescale 1ns / 1ps

module wwm_cfg import wwm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [IDX_BITS-1:0] wr_index,
  input  logic [CFG_BITS-1:0] wr_data,
  output logic [LEN_BITS-1:0] eff_len,
  output byte_t               exp_bytes [MAX_WORD],
  output logic [MAX_WORD-1:0] active
);

  logic [LEN_BITS-1:0] word_length_r;
  logic [CFG_BITS-1:0] bytes_low_r;
  logic [CFG_BITS-1:0] bytes_high_r;
  byte_t               word_b [MAX_WORD];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_length_r <= LEN_BITS'(1);
      bytes_low_r   <= '0;
      bytes_high_r  <= '0;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_WORD_LENGTH: word_length_r <= wr_data[LEN_BITS-1:0];
        CFG_BYTES_LOW:   bytes_low_r   <= wr_data;
        CFG_BYTES_HIGH:  bytes_high_r  <= wr_data;
        default: ;
      endcase
    end
  end

  // zero means one, anything past MAX_WORD means a full-length word
  always_comb begin
    if (word_length_r == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (word_length_r > LEN_BITS'(MAX_WORD)) begin
      eff_len = LEN_BITS'(MAX_WORD);
    end else begin
      eff_len = word_length_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      word_b[i]     = bytes_low_r[8*i +: 8];
      word_b[i + 8] = bytes_high_r[8*i +: 8];
    end
  end

  // cell k holds the k-th most recent byte, which must equal word[len-1-k]
  always_comb begin
    logic [LEN_BITS-1:0] idx;
    idx = '0;
    for (int k = 0; k < MAX_WORD; k++) begin
      idx          = eff_len - LEN_BITS'(1) - LEN_BITS'(k);
      exp_bytes[k] = word_b[idx[$clog2(MAX_WORD)-1:0]];
      active[k]    = (LEN_BITS'(k) < eff_len);
    end
  end

endmodule

// ----- sv/whole_word_match_counter.sv -----
// Top level of the whole-word match counter.
`timescale 1ns / 1ps

// Counts whole-word occurrences of a configured 1..16 byte word in a text streamed one
// byte per beat. The text shifts through a row of 17 byte cells that compare in parallel
// against the word, so a new byte is taken in every cycle unless in_stall is high.
// The beat flagged in_is_last yields one result beat in the next cycle (found, saturating
// count, first start position) held in an output register; the next text streams in
// unless that result is held by out_stall: in_stall rises only while the result is held
// and stalled. Configuration writes complete at once (cfg_ready is always high) and must
// be made while no text is in flight.
module whole_word_match_counter import wwm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_text_byte,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [COUNT_BITS-1:0] out_match_count,
  output logic [POS_BITS-1:0]   out_first_position,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  logic [LEN_BITS-1:0] eff_len;
  byte_t               exp_bytes [MAX_WORD];
  logic [MAX_WORD-1:0] active;

  byte_t               cell_in    [WIN_DEPTH];
  byte_t               cell_out   [WIN_DEPTH];
  byte_t               cell_exp   [WIN_DEPTH];
  cell_flags_t         cell_flags [WIN_DEPTH];

  logic [MAX_WORD-1:0]  eq_now, eq_next;
  logic [WIN_DEPTH-1:0] sp_now, sp_next;

  logic [LEN_BITS-1:0]   filled_r, filled_nxt, filled_inc;
  logic [POS_BITS-1:0]   pos_r, pos_nxt, pos_inc;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_fin;
  logic [POS_BITS-1:0]   first_r, first_nxt, first_fin;
  logic                  any_r, any_nxt, any_fin;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [COUNT_BITS-1:0] out_cnt_r, out_cnt_nxt;
  logic [POS_BITS-1:0]   out_first_r, out_first_nxt;

  logic                  accept;
  logic                  match_pre, match_end;
  logic [POS_BITS-1:0]   len_pos, start_pre, start_end;
  logic [1:0]            inc;
  logic [COUNT_BITS:0]   cnt_sum;
  logic                  any_mid;
  logic [POS_BITS-1:0]   first_mid;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;

  wwm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .eff_len   (eff_len),
    .exp_bytes (exp_bytes),
    .active    (active)
  );

  // window row: cell 0 takes the new byte, each cell feeds the next older one
  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = in_text_byte;
    end else begin : g_body
      assign cell_in[k] = cell_out[k-1];
    end
    if (k < MAX_WORD) begin : g_exp
      assign cell_exp[k] = exp_bytes[k];
      assign eq_now[k]   = cell_flags[k].eq_now;
      assign eq_next[k]  = cell_flags[k].eq_next;
    end else begin : g_tail
      assign cell_exp[k] = SPACE_BYTE;
    end
    assign sp_now[k]  = cell_flags[k].sp_now;
    assign sp_next[k] = cell_flags[k].sp_next;

    wwm_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .din      (cell_in[k]),
      .exp_byte (cell_exp[k]),
      .dout     (cell_out[k]),
      .flags    (cell_flags[k])
    );
  end

  assign filled_inc = (filled_r < LEN_BITS'(WIN_DEPTH)) ? filled_r + LEN_BITS'(1) : filled_r;
  assign pos_inc    = (pos_r < POS_MAX) ? pos_r + POS_BITS'(1) : pos_r;
  assign len_pos    = POS_BITS'(eff_len);

  // word ending at the newest held byte, closed by an incoming space
  assign match_pre = (in_text_byte == SPACE_BYTE) && (filled_r >= eff_len)
                     && (&(eq_now | ~active))
                     && ((filled_r == eff_len) || sp_now[eff_len]);
  // word ending at the text end, checked on the window after the shift
  assign match_end = in_is_last && (filled_inc >= eff_len)
                     && (&(eq_next | ~active))
                     && ((filled_inc == eff_len) || sp_next[eff_len]);

  assign start_pre = (pos_r >= len_pos) ? pos_r - len_pos : '0;
  assign start_end = (pos_inc >= len_pos) ? pos_inc - len_pos : '0;

  always_comb begin
    inc     = {1'b0, match_pre} + {1'b0, match_end};
    cnt_sum = {1'b0, cnt_r} + (COUNT_BITS+1)'(inc);
    cnt_fin = (cnt_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : cnt_sum[COUNT_BITS-1:0];

    any_mid   = any_r || match_pre;
    first_mid = (!any_r && match_pre) ? start_pre : first_r;
    any_fin   = any_mid || match_end;
    first_fin = (!any_mid && match_end) ? start_end : first_mid;
  end

  always_comb begin
    filled_nxt    = filled_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    first_nxt     = first_r;
    any_nxt       = any_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_cnt_nxt   = out_cnt_r;
    out_first_nxt = out_first_r;
    if (accept) begin
      if (in_is_last) begin
        filled_nxt    = '0;
        pos_nxt       = '0;
        cnt_nxt       = '0;
        first_nxt     = '0;
        any_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
        out_found_nxt = any_fin;
        out_cnt_nxt   = cnt_fin;
        out_first_nxt = any_fin ? first_fin : '0;
      end else begin
        filled_nxt = filled_inc;
        pos_nxt    = pos_inc;
        cnt_nxt    = cnt_fin;
        first_nxt  = first_fin;
        any_nxt    = any_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      first_r     <= '0;
      any_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      filled_r    <= filled_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      first_r     <= first_nxt;
      any_r       <= any_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_first_r <= out_first_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_match_count    = out_cnt_r;
  assign out_first_position = out_first_r;

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_is_last) |=> out_valid)
    else $error("last beat produced no result");

  a_no_match_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_count == '0 && out_first_position == '0))
    else $error("result without match carries nonzero fields");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= LEN_BITS'(WIN_DEPTH))
    else $error("window fill count past depth");

  a_count_implies_any: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> any_r)
    else $error("count nonzero without match flag");

endmodule

// ----- bench/whole_word_match_counter_test.sv -----
// Self-checking bench for whole_word_match_counter: random texts against a word predictor.
`timescale 1ns / 1ps

module whole_word_match_counter_test import wwm_pkg::*; ();

  localparam int ITEM_TARGET = 1450;
  localparam int PHASE_BEATS = 130;
  localparam int LONG_HOLD   = 400;
  localparam int IDLE_LIMIT  = 4000;

  // Predicts the per-text result from the configured word and the accepted bytes.
  class match_tally;
    typedef struct packed {
      logic                  found;
      logic [COUNT_BITS-1:0] count;
      logic [POS_BITS-1:0]   first;
    } tally_t;

    logic [4:0]            len_reg;
    logic [CFG_BITS-1:0]   bytes_lo;
    logic [CFG_BITS-1:0]   bytes_hi;
    byte_t                 window [WIN_DEPTH];
    int                    filled;
    logic [POS_BITS-1:0]   position;
    logic [COUNT_BITS-1:0] hits;
    logic [POS_BITS-1:0]   earliest;
    bit                    any_hit;
    tally_t                due [$];
    int                    beats_seen;

    function new();
      len_reg    = 5'd1;
      bytes_lo   = '0;
      bytes_hi   = '0;
      beats_seen = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = 8'h00;
      filled   = 0;
      position = '0;
      hits     = '0;
      earliest = '0;
      any_hit  = 1'b0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] val);
      case (idx)
        CFG_WORD_LENGTH: len_reg = val[4:0];
        CFG_BYTES_LOW:   bytes_lo = val;
        CFG_BYTES_HIGH:  bytes_hi = val;
        default: ;
      endcase
    endfunction

    function int word_len();
      if (len_reg == 5'd0) return 1;
      if (len_reg > MAX_WORD) return MAX_WORD;
      return len_reg;
    endfunction

    function byte_t word_byte(int i);
      if (i < 8) return bytes_lo[8*i +: 8];
      return bytes_hi[8*(i-8) +: 8];
    endfunction

    // word sits at the newest window bytes, with a space or the text start ahead of it
    function bit word_ends_here(int n);
      if (filled < n) return 1'b0;
      for (int i = 0; i < n; i++) begin
        if (window[n-1-i] != word_byte(i)) return 1'b0;
      end
      if (filled == n) return 1'b1;
      return window[n] == SPACE_BYTE;
    endfunction

    function void record_hit(int n);
      logic [POS_BITS-1:0] start;
      start = (position >= n) ? position - POS_BITS'(n) : '0;
      if (!any_hit) begin
        earliest = start;
        any_hit  = 1'b1;
      end
      if (hits != COUNT_MAX) hits++;
    endfunction

    function void take_byte(byte_t b, bit last);
      int     n;
      tally_t t;
      n = word_len();
      beats_seen++;
      if (b == SPACE_BYTE && word_ends_here(n)) record_hit(n);
      for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (filled < WIN_DEPTH) filled++;
      if (position != POS_MAX) position++;
      if (last) begin
        if (word_ends_here(n)) record_hit(n);
        t.found = any_hit;
        t.count = hits;
        t.first = any_hit ? earliest : '0;
        due.push_back(t);
        clear_text();
      end
    endfunction

    function string check_tally(logic f, logic [COUNT_BITS-1:0] c, logic [POS_BITS-1:0] p);
      tally_t want;
      string  why;
      why = "";
      if (due.size() == 0) return " result beat with no text outstanding";
      want = due.pop_front();
      if (f !== want.found) why = {why, $sformatf(" found %b exp %b", f, want.found)};
      if (c !== want.count) why = {why, $sformatf(" count %0d exp %0d", c, want.count)};
      if (p !== want.first) why = {why, $sformatf(" first %0d exp %0d", p, want.first)};
      return why;
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  byte_t                 in_text_byte = 8'h00;
  logic                  in_is_last = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_found;
  logic [COUNT_BITS-1:0] out_match_count;
  logic [POS_BITS-1:0]   out_first_position;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_WORD_LENGTH;
  logic [CFG_BITS-1:0]   cfg_data = '0;

  match_tally board;
  byte_t      feed_bytes [$];
  bit         feed_last [$];
  byte_t      text_buf [$];
  int         beats_committed = 0;
  int         mismatches = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  bit         hold_req = 1'b0;
  int         hold_cnt = 0;
  int         rx_mode = 0;
  int         rx_left = 0;
  int         idle_cycles = 0;
  byte_t      word_copy [MAX_WORD];
  int         word_n = 1;

  whole_word_match_counter uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_byte       (in_text_byte),
    .in_is_last         (in_is_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_match_count    (out_match_count),
    .out_first_position (out_first_position),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string why);
    $display("%0t: mismatch:%s", $time, why);
    mismatches++;
  endtask

  // text sender: bursts of beats with random gaps
  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_stall)) begin
      if (in_valid) begin
        void'(feed_bytes.pop_front());
        void'(feed_last.pop_front());
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (feed_bytes.size() > 0) begin
        in_valid     <= 1'b1;
        in_text_byte <= feed_bytes[0];
        in_is_last   <= feed_last[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern changes every so often; long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      out_stall <= 1'b1;
      if (hold_cnt == LONG_HOLD) begin
        hold_req <= 1'b0;
        hold_cnt = 0;
      end else begin
        hold_cnt++;
      end
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= (rx_left % 5) < 3;
      endcase
    end
  end

  always @(posedge clk) begin : watch_beats
    string why;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        why = board.check_tally(out_found, out_match_count, out_first_position);
        if (why != "") report(why);
      end
      if (in_valid && !in_stall) board.take_byte(in_text_byte, in_is_last);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(idx, val);
  endtask

  task automatic wait_drain();
    while (board.beats_seen != beats_committed || board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_word(logic [4:0] raw_len, logic [CFG_BITS-1:0] lo, logic [CFG_BITS-1:0] hi);
    wait_drain();
    write_reg(CFG_BYTES_LOW, lo);
    write_reg(CFG_BYTES_HIGH, hi);
    write_reg(CFG_WORD_LENGTH, {59'd0, raw_len});
    word_n = (raw_len == 5'd0) ? 1 : (raw_len > MAX_WORD) ? MAX_WORD : raw_len;
    for (int i = 0; i < MAX_WORD; i++)
      word_copy[i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
  endtask

  task automatic commit_text();
    foreach (text_buf[i]) begin
      feed_bytes.push_back(text_buf[i]);
      feed_last.push_back(i == text_buf.size() - 1);
    end
    beats_committed += text_buf.size();
    text_buf.delete();
  endtask

  function automatic byte_t pool_byte();
    case ($urandom_range(0, 3))
      0, 1: return word_copy[$urandom_range(0, word_n - 1)];
      2: return SPACE_BYTE;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_t word_pick();
    case ($urandom_range(0, 7))
      0: return SPACE_BYTE;
      1: return 8'h00;
      2, 3: return byte_t'($urandom_range(0, 255));
      default: return $urandom_range(0, 1) ? "a" : "b";
    endcase
  endfunction

  // mostly whole words split by spaces, with near misses, glued words and noise
  task automatic build_text();
    int tokens;
    int kind;
    int cut;
    int idx;
    tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
    if ($urandom_range(0, 3) == 0) text_buf.push_back(SPACE_BYTE);
    for (int k = 0; k < tokens; k++) begin
      if (k > 0) begin
        case ($urandom_range(0, 7))
          0: ;
          1: begin
            text_buf.push_back(SPACE_BYTE);
            text_buf.push_back(SPACE_BYTE);
          end
          2: text_buf.push_back(pool_byte());
          default: text_buf.push_back(SPACE_BYTE);
        endcase
      end
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        for (int j = 0; j < word_n; j++) text_buf.push_back(word_copy[j]);
        if (kind == 5) begin
          idx = text_buf.size() - 1 - $urandom_range(0, word_n - 1);
          text_buf[idx] = text_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
      end else if (kind == 6) begin
        cut = $urandom_range(0, word_n - 1);
        if ($urandom_range(0, 1))
          for (int j = 0; j < cut + 1; j++) text_buf.push_back(word_copy[j]);
        else
          for (int j = cut; j < word_n; j++) text_buf.push_back(word_copy[j]);
      end else if (kind < 9) begin
        repeat ($urandom_range(1, 6)) text_buf.push_back(pool_byte());
      end else begin
        repeat ($urandom_range(1, 4)) text_buf.push_back(byte_t'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 3) == 0) text_buf.push_back(SPACE_BYTE);
  endtask

  initial begin : main
    int                  phase;
    int                  start;
    logic [4:0]          raw_len;
    logic [CFG_BITS-1:0] lo;
    logic [CFG_BITS-1:0] hi;
    board = new();
    foreach (word_copy[i]) word_copy[i] = 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset word is a single zero byte: hit before a space and at text end
    text_buf = '{8'h00, SPACE_BYTE, 8'h00};
    commit_text();

    // length zero acts as one; a word that is itself a space
    set_word(5'd0, 64'h20, '1);
    text_buf = '{SPACE_BYTE, SPACE_BYTE};
    commit_text();

    // length beyond the maximum clamps to 16; all-ones then all-zero bytes
    set_word(5'd31, '1, '0);
    for (int i = 0; i < 8; i++) text_buf.push_back(8'hFF);
    for (int i = 0; i < 8; i++) text_buf.push_back(8'h00);
    commit_text();

    set_word(5'd2, 64'h6261, 64'h0);
    text_buf = '{"a", "b", SPACE_BYTE, "a", "b"};
    commit_text();

    phase = 0;
    while (beats_committed < ITEM_TARGET) begin
      case (phase)
        0: raw_len = 5'd16;
        1: raw_len = 5'd1;
        2: raw_len = 5'd0;
        3: raw_len = 5'd31;
        default: raw_len = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                                      : 5'($urandom_range(1, 16));
      endcase
      for (int i = 0; i < 8; i++) begin
        lo[8*i +: 8] = word_pick();
        hi[8*i +: 8] = word_pick();
      end
      if (phase == 1) begin
        lo = '1;
        hi = '1;
      end else if (phase == 2) begin
        lo = '0;
        hi = '0;
      end
      set_word(raw_len, lo, hi);
      if (phase == 4) hold_req <= 1'b1;
      start = beats_committed;
      while (beats_committed - start < PHASE_BEATS) begin
        build_text();
        commit_text();
        while (feed_bytes.size() > 32) @(posedge clk);
        if ($urandom_range(0, 29) == 0) wait_drain();
      end
      phase++;
    end

    wait_drain();
    repeat (10) @(posedge clk);
    if (board.pending() != 0) report(" results still outstanding at end of run");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
